// ===== design/rrts_pkg.sv =====
// Package for the round-robin thread scheduler.
// Holds slot status codes, opcodes, result status codes and parameter defaults.
// No dependencies.
package rrts_pkg;

    localparam int NUM_SLOTS_DEF    = 32;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int SPACE_BITS_DEF   = 48;

    localparam int ID_BITS = 31;
    localparam logic [ID_BITS-1:0] KERNEL_ID_RESET = 31'd1;
    localparam logic [ID_BITS-1:0] USER_ID_RESET   = 31'd100;

    // slot status codes
    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_RUNNABLE = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    // opcodes
    localparam logic [2:0] OP_CREATE_KERNEL = 3'd0;
    localparam logic [2:0] OP_CREATE_USER   = 3'd1;
    localparam logic [2:0] OP_YIELD         = 3'd2;
    localparam logic [2:0] OP_SLEEP_CHAN    = 3'd3;
    localparam logic [2:0] OP_WAKE_CHAN     = 3'd4;
    localparam logic [2:0] OP_TIMED_SLEEP   = 3'd5;
    localparam logic [2:0] OP_EXIT          = 3'd6;
    localparam logic [2:0] OP_TICK          = 3'd7;

    // result status codes
    localparam logic [1:0] RES_OK         = 2'd0;
    localparam logic [1:0] RES_TABLE_FULL = 2'd1;
    localparam logic [1:0] RES_NO_RUN     = 2'd2;

endpackage

// ===== design/round_robin_thread_scheduler.sv =====
// Round-robin thread scheduler: a ring of slot cells rotated past one head controller.
// Each transaction takes two full ring rotations (update and search, then mark the chosen
// slot running) and one result load before m_tvalid rises.
// One transaction at a time: a new one is taken only when idle, later if m_tready stalls.
// Reset (aresetn low, synchronous): slot 0 running, others unused, all fields zero,
// current slot 0, kernel ids start at 1, user ids at 100. Depends on rrts_pkg, rrts_cell.
module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int SPACE_BITS   = SPACE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[2:0], channel[18:3], tick_count[50:19], now[114:51], space_root[162:115], zero pad
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], running_slot[6:2], switched[7], new_thread_id[38:8],
    // load_space[39], space_value[87:40]
    output logic [87:0]  m_tdata
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] idx_reg;

    // latched transaction fields
    logic [2:0]              op_reg;
    logic [CHANNEL_BITS-1:0] chan_reg;
    logic [31:0]             ticks_reg;
    logic [63:0]             now_reg;
    logic [SPACE_BITS-1:0]   root_reg;

    logic [IW-1:0]      cur_reg;
    logic [ID_BITS-1:0] kid_reg, uid_reg;

    // search and create bookkeeping over the first rotation
    logic                  slot_found_reg;
    logic [ID_BITS-1:0]    new_id_reg;
    logic                  hi_found_reg, lo_found_reg;
    logic [IW-1:0]         hi_idx_reg, lo_idx_reg;
    logic [SPACE_BITS-1:0] hi_space_reg, lo_space_reg, prev_space_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    // ring taps
    logic [2:0]              st_q   [NUM_SLOTS];
    logic [ID_BITS-1:0]      id_q   [NUM_SLOTS];
    logic [CHANNEL_BITS-1:0] ch_q   [NUM_SLOTS];
    logic [63:0]             dl_q   [NUM_SLOTS];
    logic [SPACE_BITS-1:0]   sp_q   [NUM_SLOTS];

    // head slot after this cycle's update, fed back into the tail cell
    logic [2:0]              h_st;
    logic [ID_BITS-1:0]      h_id;
    logic [CHANNEL_BITS-1:0] h_ch;
    logic [63:0]             h_dl;
    logic [SPACE_BITS-1:0]   h_sp;

    logic shift;
    logic is_create, is_resched, at_cur;
    logic take_slot;
    logic any_found;
    logic [IW-1:0] tgt_idx;
    logic [SPACE_BITS-1:0] tgt_space;
    logic do_switch, do_load;
    logic [1:0] res_status;

    assign shift      = (state_reg == S_PASS1) || (state_reg == S_PASS2);
    assign is_create  = (op_reg == OP_CREATE_KERNEL) || (op_reg == OP_CREATE_USER);
    assign is_resched = !is_create && (op_reg != OP_WAKE_CHAN);
    assign at_cur     = (idx_reg == cur_reg);

    assign any_found = hi_found_reg || lo_found_reg;
    assign tgt_idx   = hi_found_reg ? hi_idx_reg : lo_idx_reg;
    assign tgt_space = hi_found_reg ? hi_space_reg : lo_space_reg;
    assign do_switch = any_found && (tgt_idx != cur_reg);
    assign do_load   = do_switch && (tgt_space != '0) && (tgt_space != prev_space_reg);

    always_comb begin
        if (is_create && !slot_found_reg) begin
            res_status = RES_TABLE_FULL;
        end else if ((op_reg == OP_EXIT) && !any_found) begin
            res_status = RES_NO_RUN;
        end else begin
            res_status = RES_OK;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_ring
            if (gi == NUM_SLOTS - 1) begin : g_tail
                rrts_cell #(
                    .CHANNEL_BITS (CHANNEL_BITS),
                    .SPACE_BITS   (SPACE_BITS),
                    .RESET_STATUS ((gi == 0) ? ST_RUNNING : ST_UNUSED)
                ) u_cell (
                    .aclk, .aresetn, .shift,
                    .status_in (h_st), .ident_in (h_id), .channel_in (h_ch),
                    .deadline_in (h_dl), .space_in (h_sp),
                    .status_q (st_q[gi]), .ident_q (id_q[gi]), .channel_q (ch_q[gi]),
                    .deadline_q (dl_q[gi]), .space_q (sp_q[gi])
                );
            end else begin : g_mid
                rrts_cell #(
                    .CHANNEL_BITS (CHANNEL_BITS),
                    .SPACE_BITS   (SPACE_BITS),
                    .RESET_STATUS ((gi == 0) ? ST_RUNNING : ST_UNUSED)
                ) u_cell (
                    .aclk, .aresetn, .shift,
                    .status_in (st_q[gi+1]), .ident_in (id_q[gi+1]),
                    .channel_in (ch_q[gi+1]), .deadline_in (dl_q[gi+1]),
                    .space_in (sp_q[gi+1]),
                    .status_q (st_q[gi]), .ident_q (id_q[gi]), .channel_q (ch_q[gi]),
                    .deadline_q (dl_q[gi]), .space_q (sp_q[gi])
                );
            end
        end
    endgenerate

    // Head update: the slot at cell 0 has index idx_reg. Every per-slot change of the
    // opcode is final once the slot leaves the head, so the search sees settled status.
    always_comb begin
        h_st = st_q[0];
        h_id = id_q[0];
        h_ch = ch_q[0];
        h_dl = dl_q[0];
        h_sp = sp_q[0];
        take_slot = 1'b0;
        if (state_reg == S_PASS1) begin
            case (op_reg)
                OP_CREATE_KERNEL, OP_CREATE_USER: begin
                    // reap zombies, then claim the lowest unused slot
                    if (h_st == ST_ZOMBIE) begin
                        h_st = ST_UNUSED;
                        h_sp = '0;
                    end
                    if ((h_st == ST_UNUSED) && !slot_found_reg) begin
                        take_slot = 1'b1;
                        h_st = ST_RUNNABLE;
                        if (op_reg == OP_CREATE_KERNEL) begin
                            h_id = kid_reg;
                            h_sp = '0;
                        end else begin
                            h_id = uid_reg;
                            h_sp = root_reg;
                        end
                    end
                end
                OP_YIELD: begin
                    if (at_cur) h_st = ST_RUNNABLE;
                end
                OP_SLEEP_CHAN: begin
                    if (at_cur) begin
                        h_ch = chan_reg;
                        h_st = ST_SLEEPING;
                    end
                end
                OP_WAKE_CHAN: begin
                    if ((h_st == ST_SLEEPING) && (h_ch == chan_reg)) begin
                        h_st = ST_RUNNABLE;
                        h_ch = '0;
                    end
                end
                OP_TIMED_SLEEP: begin
                    if (at_cur) begin
                        h_ch = '0;
                        h_dl = now_reg + {32'd0, ticks_reg};
                        h_st = ST_SLEEPING;
                    end
                end
                OP_EXIT: begin
                    if (at_cur) h_st = ST_ZOMBIE;
                end
                default: begin
                    // timer tick: wake expired timed sleepers, demote the running thread
                    if ((h_st == ST_SLEEPING) && (h_ch == '0) && (h_dl <= now_reg)) begin
                        h_st = ST_RUNNABLE;
                    end
                    if (at_cur && (h_st == ST_RUNNING)) h_st = ST_RUNNABLE;
                end
            endcase
        end else if (state_reg == S_PASS2) begin
            // promote the chosen slot; a refused exit keeps the current thread running
            if (is_resched && any_found && (idx_reg == tgt_idx)) begin
                h_st = ST_RUNNING;
            end else if ((op_reg == OP_EXIT) && !any_found && at_cur) begin
                h_st = ST_RUNNING;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_PASS1;
            end
            S_PASS1: begin
                if (idx_reg == LAST_IDX) state_next = S_PASS2;
            end
            S_PASS2: begin
                if (idx_reg == LAST_IDX) state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            cur_reg      <= '0;
            kid_reg      <= KERNEL_ID_RESET;
            uid_reg      <= USER_ID_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (shift) idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                if (do_switch) cur_reg <= tgt_idx;
                if (is_create && slot_found_reg) begin
                    if (op_reg == OP_CREATE_KERNEL) kid_reg <= kid_reg + 1'b1;
                    else                            uid_reg <= uid_reg + 1'b1;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers: capture the transaction, track search results, build the result
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg         <= s_tdata[2:0];
            chan_reg       <= CHANNEL_BITS'(s_tdata[18:3]);
            ticks_reg      <= s_tdata[50:19];
            now_reg        <= s_tdata[114:51];
            root_reg       <= SPACE_BITS'(s_tdata[162:115]);
            slot_found_reg <= 1'b0;
            new_id_reg     <= '0;
            hi_found_reg   <= 1'b0;
            lo_found_reg   <= 1'b0;
            hi_idx_reg     <= '0;
            lo_idx_reg     <= '0;
            hi_space_reg   <= '0;
            lo_space_reg   <= '0;
            prev_space_reg <= '0;
        end
        if (state_reg == S_PASS1) begin
            if (take_slot) begin
                slot_found_reg <= 1'b1;
                new_id_reg     <= h_id;
            end
            if (at_cur) prev_space_reg <= sp_q[0];
            if (is_resched && (h_st == ST_RUNNABLE)) begin
                // first runnable above current wins; else first at or below it
                if ((idx_reg > cur_reg) && !hi_found_reg) begin
                    hi_found_reg <= 1'b1;
                    hi_idx_reg   <= idx_reg;
                    hi_space_reg <= h_sp;
                end
                if ((idx_reg <= cur_reg) && !lo_found_reg) begin
                    lo_found_reg <= 1'b1;
                    lo_idx_reg   <= idx_reg;
                    lo_space_reg <= h_sp;
                end
            end
        end
        if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg[1:0]   <= res_status;
            m_tdata_reg[6:2]   <= 5'(do_switch ? tgt_idx : cur_reg);
            m_tdata_reg[7]     <= do_switch;
            m_tdata_reg[38:8]  <= (is_create && slot_found_reg) ? new_id_reg : '0;
            m_tdata_reg[39]    <= do_load;
            m_tdata_reg[87:40] <= do_load ? 48'(tgt_space) : 48'd0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/rrts_cell.sv =====
// One thread slot of the scheduler ring.
// Depends on rrts_pkg for the id width, parameter defaults and slot status codes.
module rrts_cell
    import rrts_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int SPACE_BITS   = SPACE_BITS_DEF,
    parameter logic [2:0] RESET_STATUS = ST_UNUSED
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    shift,
    input  logic [2:0]              status_in,
    input  logic [ID_BITS-1:0]      ident_in,
    input  logic [CHANNEL_BITS-1:0] channel_in,
    input  logic [63:0]             deadline_in,
    input  logic [SPACE_BITS-1:0]   space_in,
    output logic [2:0]              status_q,
    output logic [ID_BITS-1:0]      ident_q,
    output logic [CHANNEL_BITS-1:0] channel_q,
    output logic [63:0]             deadline_q,
    output logic [SPACE_BITS-1:0]   space_q
);

    logic [2:0]              status_reg;
    logic [ID_BITS-1:0]      ident_reg;
    logic [CHANNEL_BITS-1:0] channel_reg;
    logic [63:0]             deadline_reg;
    logic [SPACE_BITS-1:0]   space_reg;

    // advance the neighbor's slot into this cell on every shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg   <= RESET_STATUS;
            ident_reg    <= '0;
            channel_reg  <= '0;
            deadline_reg <= '0;
            space_reg    <= '0;
        end else if (shift) begin
            status_reg   <= status_in;
            ident_reg    <= ident_in;
            channel_reg  <= channel_in;
            deadline_reg <= deadline_in;
            space_reg    <= space_in;
        end
    end

    assign status_q   = status_reg;
    assign ident_q    = ident_reg;
    assign channel_q  = channel_reg;
    assign deadline_q = deadline_reg;
    assign space_q    = space_reg;

endmodule

// ===== dv/tb_round_robin_thread_scheduler.sv =====
// Testbench for the round-robin thread scheduler: random and directed opcode streams
// checked against a behavioral slot-table predictor. Depends on rrts_pkg and the RTL top.
module tb_round_robin_thread_scheduler;
    import rrts_pkg::*;

    localparam int SLOTS = 32;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [47:0] space_root;
        logic [63:0] now;
        logic [31:0] tick_count;
        logic [15:0] channel;
        logic [2:0]  opcode;
    } sched_cmd_t;

    typedef struct packed {
        logic [47:0] space_value;
        logic        load_space;
        logic [30:0] new_thread_id;
        logic        switched;
        logic [4:0]  running_slot;
        logic [1:0]  status;
    } sched_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    round_robin_thread_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state: a private copy of the slot table
    logic [2:0]  p_status   [SLOTS];
    logic [30:0] p_ident    [SLOTS];
    logic [15:0] p_chan     [SLOTS];
    logic [63:0] p_deadline [SLOTS];
    logic [47:0] p_space    [SLOTS];
    logic [4:0]  p_cur;
    logic [30:0] p_kid, p_uid;

    sched_cmd_t pending_cmds[$];
    sched_res_t expected_results[$];
    int  errors = 0;
    int  cycle = 0;
    int  n_results = 0;
    int  n_switches = 0;
    int  n_full = 0;
    bit  calm = 1'b0;       // no idling in the last part
    bit  hold_master = 1'b0;

    function automatic void table_reset();
        for (int i = 0; i < SLOTS; i++) begin
            p_status[i] = ST_UNUSED;
            p_ident[i] = '0;
            p_chan[i] = '0;
            p_deadline[i] = '0;
            p_space[i] = '0;
        end
        p_status[0] = ST_RUNNING;
        p_cur = '0;
        p_kid = KERNEL_ID_RESET;
        p_uid = USER_ID_RESET;
    endfunction

    // round-robin search from current+1; fills the switch fields of r
    function automatic bit pick_next(inout sched_res_t r);
        logic [4:0] prev;
        logic [4:0] idx;
        prev = p_cur;
        for (int i = 1; i <= SLOTS; i++) begin
            idx = prev + 5'(i);
            if (p_status[idx] == ST_RUNNABLE) begin
                p_status[idx] = ST_RUNNING;
                if (idx != prev) begin
                    r.switched = 1'b1;
                    if (p_space[idx] != 0 && p_space[idx] != p_space[prev]) begin
                        r.load_space = 1'b1;
                        r.space_value = p_space[idx];
                    end
                    p_cur = idx;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sched_res_t schedule_step(sched_cmd_t c);
        sched_res_t r;
        int found;
        logic [4:0] cur;
        r = '0;
        cur = p_cur;
        case (c.opcode)
            OP_CREATE_KERNEL, OP_CREATE_USER: begin
                found = SLOTS;
                for (int i = 0; i < SLOTS; i++) begin
                    if (p_status[i] == ST_ZOMBIE) begin
                        p_status[i] = ST_UNUSED;
                        p_space[i] = '0;
                    end
                    if (p_status[i] == ST_UNUSED && found == SLOTS) found = i;
                end
                if (found == SLOTS) begin
                    r.status = RES_TABLE_FULL;
                end else begin
                    p_status[found] = ST_RUNNABLE;
                    if (c.opcode == OP_CREATE_KERNEL) begin
                        r.new_thread_id = p_kid;
                        p_kid = p_kid + 31'd1;
                        p_space[found] = '0;
                    end else begin
                        r.new_thread_id = p_uid;
                        p_uid = p_uid + 31'd1;
                        p_space[found] = c.space_root;
                    end
                    p_ident[found] = r.new_thread_id;
                end
            end
            OP_YIELD: begin
                p_status[cur] = ST_RUNNABLE;
                void'(pick_next(r));
            end
            OP_SLEEP_CHAN: begin
                p_chan[cur] = c.channel;
                p_status[cur] = ST_SLEEPING;
                void'(pick_next(r));
            end
            OP_WAKE_CHAN: begin
                for (int i = 0; i < SLOTS; i++)
                    if (p_status[i] == ST_SLEEPING && p_chan[i] == c.channel) begin
                        p_status[i] = ST_RUNNABLE;
                        p_chan[i] = '0;
                    end
            end
            OP_TIMED_SLEEP: begin
                p_chan[cur] = '0;
                p_deadline[cur] = c.now + 64'(c.tick_count);
                p_status[cur] = ST_SLEEPING;
                void'(pick_next(r));
            end
            OP_EXIT: begin
                p_status[cur] = ST_ZOMBIE;
                if (!pick_next(r)) begin
                    p_status[cur] = ST_RUNNING;
                    r.status = RES_NO_RUN;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++)
                    if (p_status[i] == ST_SLEEPING && p_chan[i] == 0 &&
                        p_deadline[i] <= c.now) begin
                        p_status[i] = ST_RUNNABLE;
                    end
                if (p_status[cur] == ST_RUNNING) p_status[cur] = ST_RUNNABLE;
                void'(pick_next(r));
            end
        endcase
        r.running_slot = p_cur;
        return r;
    endfunction

    function automatic sched_cmd_t make_cmd(logic [2:0] op, logic [15:0] ch,
                                            logic [31:0] tk, logic [63:0] nw,
                                            logic [47:0] rt);
        sched_cmd_t c;
        c.opcode = op;
        c.channel = ch;
        c.tick_count = tk;
        c.now = nw;
        c.space_root = rt;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small channel set so sleep and wake meet; sometimes any value
    function automatic logic [15:0] pick_chan();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 3));
    endfunction

    function automatic logic [47:0] pick_root();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 48'($urandom_range(1, 3));
            default: return {16'($urandom()), $urandom()};
        endcase
    endfunction

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // driver: advance to the next queued command once the current one is taken
    int s_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered transaction
        end else if (s_idle > 0) begin
            s_idle <= s_idle - 1;
            s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     (calm || $urandom_range(0, 5) != 0)) begin
            s_tdata <= {5'd0, pending_cmds.pop_front()};
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
            if (!calm && pending_cmds.size() > 0) s_idle <= $urandom_range(1, 4);
        end
    end

    // predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(schedule_step(sched_cmd_t'(s_tdata[162:0])));
    end

    // receiver ready with random stall bursts, plus the long hold-off
    int m_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_master) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (m_idle > 0) begin
            m_idle <= m_idle - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            m_idle <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        sched_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sched_res_t'(m_tdata);
            if (expected_results.size() == 0) begin
                $error("result with no prediction waiting: %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (want.switched) n_switches++;
                if (want.status == RES_TABLE_FULL) n_full++;
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.running_slot !== want.running_slot) begin
                    $error("running_slot exp %0d got %0d", want.running_slot,
                           got.running_slot); errors++;
                end
                if (got.switched !== want.switched) begin
                    $error("switched exp %0d got %0d", want.switched, got.switched);
                    errors++;
                end
                if (got.new_thread_id !== want.new_thread_id) begin
                    $error("new_thread_id exp %0d got %0d", want.new_thread_id,
                           got.new_thread_id); errors++;
                end
                if (got.load_space !== want.load_space) begin
                    $error("load_space exp %0d got %0d", want.load_space, got.load_space);
                    errors++;
                end
                if (got.space_value !== want.space_value) begin
                    $error("space_value exp %h got %h", want.space_value,
                           got.space_value); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("[round_robin_thread_scheduler] ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        int op;
        logic [63:0] base_now;
        table_reset();

        // directed: extremes, every opcode, repeated creates, exits, wraps
        pending_cmds.push_back(make_cmd(OP_EXIT, 0, 0, 0, 0));            // nothing runnable
        pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0));           // lone yield
        pending_cmds.push_back(make_cmd(OP_CREATE_USER, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(OP_CREATE_KERNEL, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0));           // load space
        pending_cmds.push_back(make_cmd(OP_SLEEP_CHAN, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_WAKE_CHAN, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TIMED_SLEEP, 0, '1, '1, 0));   // deadline wraps
        pending_cmds.push_back(make_cmd(OP_SLEEP_CHAN, 0, 0, 0, 0));      // channel 0 sleep
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, '1, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_EXIT, 0, 0, 0, 0));
        for (int i = 0; i < 12; i++)                                      // alternating kernel and user creates
            pending_cmds.push_back(make_cmd(3'(i % 2), 0, 0, 0, 48'(i)));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h5555, 32'hAAAA_AAAA, 0, 48'h5555));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // random: well-formed mixes with small channels and clustered tick values
        base_now = 64'd1000;
        for (int n = 0; n < 1300; n++) begin
            if (n == 400) begin
                // long receiver hold-off while the sender keeps offering
                wait (pending_cmds.size() == 0);
                for (int k = 0; k < 40; k++)
                    pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0));
                hold_master = 1'b1;
                repeat (600) @(posedge aclk);
                hold_master = 1'b0;
            end
            if (n == 1100) calm = 1'b1;
            op = $urandom_range(0, 99);
            base_now = base_now + $urandom_range(0, 20);
            if (op < 18)      pending_cmds.push_back(make_cmd(OP_CREATE_KERNEL,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else if (op < 36) pending_cmds.push_back(make_cmd(OP_CREATE_USER,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else if (op < 48) pending_cmds.push_back(make_cmd(OP_YIELD,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else if (op < 58) pending_cmds.push_back(make_cmd(OP_SLEEP_CHAN,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else if (op < 68) pending_cmds.push_back(make_cmd(OP_WAKE_CHAN,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else if (op < 76) pending_cmds.push_back(make_cmd(OP_TIMED_SLEEP, pick_chan(),
                                  ($urandom_range(0, 7) == 0) ? $urandom() :
                                  32'($urandom_range(0, 60)),
                                  ($urandom_range(0, 15) == 0) ? rand64() : base_now,
                                  pick_root()));
            else if (op < 88) pending_cmds.push_back(make_cmd(OP_EXIT,
                                  pick_chan(), $urandom(), rand64(), pick_root()));
            else              pending_cmds.push_back(make_cmd(OP_TICK, pick_chan(),
                                  $urandom(),
                                  ($urandom_range(0, 15) == 0) ? rand64() : base_now,
                                  pick_root()));
            while (pending_cmds.size() > 8) @(posedge aclk);
        end

        wait (pending_cmds.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);

        $display("Covered %0d scheduler operations: %0d thread switches, %0d full-table",
                 n_results, n_switches, n_full);
        $display("creates, plus a long result stall with input backpressure.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[round_robin_thread_scheduler] OK");
        end else begin
            $display("[round_robin_thread_scheduler] ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/rrts_pkg.sv
design/rrts_cell.sv
design/round_robin_thread_scheduler.sv
dv/tb_round_robin_thread_scheduler.sv
